FILE: hw/rtl/haar2d_pkg.sv
// Shared types, constants and byte arithmetic for the 2D Haar transform block.
package haar2d_pkg;

	localparam int unsigned PIX_W          = 8;
	localparam int unsigned SIZE_W         = 10;
	localparam int unsigned COORD_W        = 10;
	localparam int unsigned STORE_DEPTH    = 512;
	localparam int unsigned STORE_AW       = $clog2(STORE_DEPTH);
	localparam int unsigned COUNT_W        = STORE_AW + 1;
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;
	localparam int unsigned OUT_TDATA_W    = 32;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	typedef enum logic {
		REG_HALF_WIDTH  = 1'b0,
		REG_HALF_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BEAT_SUM_A,
		BEAT_DIF_A,
		BEAT_SUM_D,
		BEAT_DIF_D
	} beat_t;

	// One odd-row pixel pair: stored top pair, new bottom pair and its place.
	typedef struct packed {
		logic [PIX_W-1:0]    at;
		logic [PIX_W-1:0]    dt;
		logic [PIX_W-1:0]    av;
		logic [PIX_W-1:0]    dv;
		logic [STORE_AW-1:0] j;
		logic [STORE_AW-1:0] c;
	} job_t;

	function automatic logic [PIX_W-1:0] avg8(input logic [PIX_W-1:0] x,
			input logic [PIX_W-1:0] y);
		logic [PIX_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[PIX_W:1];
	endfunction

	// Half difference truncated toward zero, wrapped to a byte.
	function automatic logic [PIX_W-1:0] half_diff8(input logic [PIX_W-1:0] x,
			input logic [PIX_W-1:0] y);
		logic [PIX_W:0]   d;
		logic [PIX_W-1:0] m;
		d = (x >= y) ? ({1'b0, x} - {1'b0, y}) : ({1'b0, y} - {1'b0, x});
		m = d[PIX_W:1];
		return (x >= y) ? m : (PIX_W'(0) - m);
	endfunction

	function automatic logic [SIZE_W-1:0] clamp_half(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] lim);
		if (v == '0) begin
			return SIZE_W'(1);
		end
		if (v > lim) begin
			return lim;
		end
		return v;
	endfunction

endpackage

FILE: hw/rtl/haar2d_front.sv
// Front end: pixel intake, raster counters, horizontal step and line store.
module haar2d_front import haar2d_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    pixel,
	input  logic                frame_start,
	input  logic [SIZE_W-1:0]   size_w,
	input  logic [SIZE_W-1:0]   size_h,
	output logic                job_valid,
	input  logic                job_ready,
	output job_t                job
);

	logic [COUNT_W-1:0]  col_q, row_q;
	logic [PIX_W-1:0]    held_q;
	logic [COUNT_W-1:0]  col_cur, row_cur;
	logic                accept, last_col, last_row, emit, store_wr;
	logic [PIX_W-1:0]    av, dv;
	logic [STORE_AW-1:0] pair_c;

	logic                valid_s1;
	logic [PIX_W-1:0]    av_s1, dv_s1;
	logic [STORE_AW-1:0] j_s1, c_s1;
	logic [2*PIX_W-1:0]  top_s1;

	// Line store: average in the low byte, half difference in the high byte.
	logic [2*PIX_W-1:0]  line_store [STORE_DEPTH];

	assign in_ready = !valid_s1 || job_ready;
	assign accept   = in_valid && in_ready;
	assign col_cur  = frame_start ? '0 : col_q;
	assign row_cur  = frame_start ? '0 : row_q;
	assign pair_c   = col_cur[COUNT_W-1:1];
	assign av       = avg8(held_q, pixel);
	assign dv       = half_diff8(held_q, pixel);
	assign last_col = {1'b0, col_cur} >= ({size_w, 1'b0} - (COUNT_W+1)'(1));
	assign last_row = {1'b0, row_cur} >= ({size_h, 1'b0} - (COUNT_W+1)'(1));
	assign emit     = accept && col_cur[0] && row_cur[0];
	assign store_wr = accept && col_cur[0] && !row_cur[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (!col_cur[0]) begin
					held_q <= pixel;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_cur + COUNT_W'(1);
				end else begin
					col_q <= col_cur + COUNT_W'(1);
					row_q <= row_cur;
				end
			end
			if (accept) begin
				valid_s1 <= emit;
			end else if (job_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			line_store[pair_c] <= {dv, av};
		end
		if (emit) begin
			top_s1 <= line_store[pair_c];
			av_s1  <= av;
			dv_s1  <= dv;
			j_s1   <= row_cur[COUNT_W-1:1];
			c_s1   <= pair_c;
		end
	end

	assign job_valid = valid_s1;
	assign job = '{at: top_s1[PIX_W-1:0], dt: top_s1[2*PIX_W-1:PIX_W],
		av: av_s1, dv: dv_s1, j: j_s1, c: c_s1};

endmodule

FILE: hw/rtl/haar2d_queue.sv
// Short job queue between the front end and the coefficient back end.
module haar2d_queue import haar2d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	job_t                   slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push, pop;

	assign push_ready = count_q != QUEUE_CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hw/rtl/haar2d_back.sv
// Back end: vertical step and four-beat coefficient output with its register.
module haar2d_back import haar2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  job_t               job,
	input  logic [SIZE_W-1:0]  size_w,
	input  logic [SIZE_W-1:0]  size_h,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   coeff,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_col,
	output logic               out_last
);

	job_t                job_q;
	logic                job_valid_q;
	beat_t               beat_q, beat_d;
	logic                out_valid_q;
	logic [PIX_W-1:0]    coeff_q;
	logic [COORD_W-1:0]  row_q, col_q;
	logic                last_q;

	logic                load, fire, done;
	logic [COORD_W-1:0]  j10, c10, jh, cw;
	logic [PIX_W-1:0]    beat_coeff;
	logic [COORD_W-1:0]  beat_row, beat_col;
	logic                beat_last;

	assign load      = !out_valid_q || out_ready;
	assign fire      = job_valid_q && load;
	assign done      = fire && (beat_q == BEAT_DIF_D);
	assign job_ready = !job_valid_q || done;

	assign j10 = COORD_W'(job_q.j);
	assign c10 = COORD_W'(job_q.c);
	assign jh  = j10 + COORD_W'(size_h);
	assign cw  = c10 + COORD_W'(size_w);

	always_comb begin
		beat_d = beat_q;
		if (fire) begin
			case (beat_q)
				BEAT_SUM_A: beat_d = BEAT_DIF_A;
				BEAT_DIF_A: beat_d = BEAT_SUM_D;
				BEAT_SUM_D: beat_d = BEAT_DIF_D;
				BEAT_DIF_D: beat_d = BEAT_SUM_A;
				default:    beat_d = BEAT_SUM_A;
			endcase
		end
	end

	always_comb begin
		case (beat_q)
			BEAT_SUM_A: begin
				beat_coeff = avg8(job_q.at, job_q.av);
				beat_row   = j10;
				beat_col   = c10;
				beat_last  = 1'b0;
			end
			BEAT_DIF_A: begin
				beat_coeff = half_diff8(job_q.at, job_q.av);
				beat_row   = jh;
				beat_col   = c10;
				beat_last  = 1'b0;
			end
			BEAT_SUM_D: begin
				beat_coeff = avg8(job_q.dt, job_q.dv);
				beat_row   = j10;
				beat_col   = cw;
				beat_last  = 1'b0;
			end
			BEAT_DIF_D: begin
				beat_coeff = half_diff8(job_q.dt, job_q.dv);
				beat_row   = jh;
				beat_col   = cw;
				beat_last  = 1'b1;
			end
			default: begin
				beat_coeff = '0;
				beat_row   = '0;
				beat_col   = '0;
				beat_last  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			beat_q      <= BEAT_SUM_A;
			out_valid_q <= 1'b0;
		end else begin
			beat_q <= beat_d;
			if (job_ready) begin
				job_valid_q <= job_valid;
			end
			if (load) begin
				out_valid_q <= job_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			job_q <= job;
		end
		if (fire) begin
			coeff_q <= beat_coeff;
			row_q   <= beat_row;
			col_q   <= beat_col;
			last_q  <= beat_last;
		end
	end

	assign out_valid = out_valid_q;
	assign coeff     = coeff_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign out_last  = last_q;

endmodule

FILE: hw/rtl/haar_2d_forward_8bit_unit.sv
// One-level forward 2D Haar transform over an 8-bit grayscale pixel stream.
//
// Pixels enter on the s_axis channel in raster order, one item each, with
// tuser set on the first pixel of a frame. On odd rows every second pixel
// of a pair yields four coefficients on the m_axis channel, tagged with
// their row and column in the quadrant layout; tlast marks the fourth.
// Even rows yield no items, fill the line store and take one pixel per cycle
// while the front stage holds no unqueued job. On odd rows the output sends
// one coefficient per cycle while the receiver is ready, four per pixel pair,
// so the single result port of the back end holds back the input. A group's
// first coefficient passes front stage, queue and job register to the output.
// A two-entry job queue lets the front end keep taking pixels while the
// back end works. Once the queue is full and the front stage holds a job,
// s_axis tready drops; on a long odd row this happens even with the receiver
// ready, and a receiver stall keeps it low until items are taken again.
// Reset clears the counters and sets both size registers to 256; the line
// store holds no valid data until an even row has written it.
// Sizes are written through cfg_we/cfg_index/cfg_data; the user must do so only while no items
// are in flight, which the block itself does not enforce; out-of-range sizes are clamped.
module haar_2d_forward_8bit_unit import haar2d_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
	input  logic                   s_axis_tuser,   // [0] frame_start
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] coeff, [17:8] out_row,
	                                               // [27:18] out_col, [31:28] zero
	output logic                   m_axis_tlast,   // last_of_group
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [SIZE_W-1:0]      cfg_data
);

	localparam int unsigned HW_RAW = MAX_WIDTH / 2;
	localparam int unsigned HH_RAW = MAX_HEIGHT / 2;
	localparam int unsigned HW_LIM = (HW_RAW > STORE_DEPTH) ? STORE_DEPTH
		: ((HW_RAW < 1) ? 1 : HW_RAW);
	localparam int unsigned HH_LIM = (HH_RAW > STORE_DEPTH) ? STORE_DEPTH
		: ((HH_RAW < 1) ? 1 : HH_RAW);

	logic [SIZE_W-1:0]  half_width_q, half_height_q;
	logic [SIZE_W-1:0]  size_w, size_h;
	logic               push_valid, push_ready, pop_valid, pop_ready;
	job_t               push_job, pop_job;
	logic [PIX_W-1:0]   coeff;
	logic [COORD_W-1:0] out_row, out_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= SIZE_RESET;
			half_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_HALF_WIDTH:  half_width_q  <= cfg_data;
				REG_HALF_HEIGHT: half_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign size_w = clamp_half(half_width_q, SIZE_W'(HW_LIM));
	assign size_h = clamp_half(half_height_q, SIZE_W'(HH_LIM));

	haar2d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.pixel       (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.size_w      (size_w),
		.size_h      (size_h),
		.job_valid   (push_valid),
		.job_ready   (push_ready),
		.job         (push_job)
	);

	haar2d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_job)
	);

	haar2d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.size_w    (size_w),
		.size_h    (size_h),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.coeff     (coeff),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - PIX_W - 2*COORD_W)'(0), out_col, out_row, coeff};

	// The input may only stall while the front stage holds an unqueued job.
	a_ready_when_front_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!push_valid |-> s_axis_tready)
		else $error("pixel input stalled with an empty front stage");

	// A full queue must hold back the front stage.
	a_full_queue_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |-> !s_axis_tready)
		else $error("pixel taken while its job could not be queued");

	// Clamped sizes always stay inside the line store and the image limits.
	a_sizes_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		size_w != '0 && size_h != '0 && size_w <= SIZE_W'(HW_LIM)
		&& size_h <= SIZE_W'(HH_LIM))
		else $error("clamped image size out of range");

endmodule
